@@ rtl/swfc_pkg.sv @@
package swfc_pkg;

  // crc8 parameters for the word check
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // positions inside a six-byte reply
  localparam logic [2:0] POS_HI0  = 3'd0;
  localparam logic [2:0] POS_LO0  = 3'd1;
  localparam logic [2:0] POS_CRC0 = 3'd2;
  localparam logic [2:0] POS_HI1  = 3'd3;
  localparam logic [2:0] POS_LO1  = 3'd4;
  localparam logic [2:0] POS_CRC1 = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } rx_item_t;

  typedef struct packed {
    logic [15:0] co2_ppm;
    logic [15:0] voc_word;
    logic        status;
  } result_t;

  // result of one frame step, handed to the result register
  typedef struct packed {
    logic    hit;
    result_t data;
  } frame_res_t;

  // one byte of crc8, msb first, all eight shifts unrolled
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/sensor_word_frame_crc_check.sv @@
// Checks a six-byte sensor reply taken one byte per request: two words, each a
// high byte, a low byte and a crc8 byte (polynomial 0x31, init 0xFF, msb first,
// restarted per word). frame_start forces the byte to be byte zero and drops a
// partial frame; otherwise the position wraps after six bytes. On the sixth
// byte one result is sent with both words and status 1 if either crc failed.
// A byte is taken every cycle: the eight-shift crc update is unrolled between
// the input register and the result register, which the last byte passes in
// that order to reach result_valid. The block stalls only while a result waits.
module sensor_word_frame_crc_check (
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_stall,
  input  swfc_pkg::rx_item_t rx_item,
  output logic               result_valid,
  input  logic               result_stall,
  output swfc_pkg::result_t  result
);

  logic                 advance;
  logic                 hold_valid;
  swfc_pkg::rx_item_t   hold_item;
  logic                 fire;
  swfc_pkg::frame_res_t res;

  assign fire = hold_valid && advance;

  // input register
  swfc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_item    (rx_item),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  // frame position, crc and word capture
  swfc_frame u_frame (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (hold_item),
    .res  (res)
  );

  // result register
  swfc_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .res          (res),
    .load_ready   (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // a new result only follows a processed byte
  a_result_from_fire: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(fire))
    else $error("result appeared without a processed byte");

  // a held byte is not lost while the result side is blocked
  a_hold_kept: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !advance |=> hold_valid && $stable(hold_item))
    else $error("held byte dropped while blocked");

  // a frame result is only raised for a processed byte
  a_hit_needs_fire: assert property (@(posedge clk) disable iff (rst)
    res.hit |-> hold_valid && advance)
    else $error("frame result without a processed byte");

  // after reset no result is pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !hold_valid)
    else $error("pipeline not empty after reset");

endmodule

@@ rtl/swfc_in_stage.sv @@
module swfc_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_stall,
  input  swfc_pkg::rx_item_t rx_item,
  input  logic               advance,
  output logic               hold_valid,
  output swfc_pkg::rx_item_t hold_item
);

  logic rx_accept;

  // hold the request until the frame logic takes it
  assign rx_stall  = hold_valid && !advance;
  assign rx_accept = rx_valid && !rx_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= rx_accept || (hold_valid && !advance);
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (rx_accept) begin
      hold_item <= rx_item;
    end
  end

endmodule

@@ rtl/swfc_frame.sv @@
module swfc_frame (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  swfc_pkg::rx_item_t   item,
  output swfc_pkg::frame_res_t res
);

  logic [2:0]  byte_position, byte_position_next;
  logic [7:0]  running_crc, running_crc_next;
  logic [15:0] first_word, first_word_next;
  logic [7:0]  second_high_byte, second_high_byte_next;
  logic [7:0]  second_low_byte, second_low_byte_next;
  logic        crc_fail_seen, crc_fail_seen_next;
  logic [2:0]  pos;
  logic [7:0]  b;
  logic        crc_bad;

  assign b       = item.data_byte;
  assign crc_bad = running_crc != b;

  // frame start or an unreachable position opens a new frame
  always_comb begin
    if (item.frame_start || byte_position > swfc_pkg::POS_CRC1) begin
      pos = swfc_pkg::POS_HI0;
    end else begin
      pos = byte_position;
    end
  end

  // per-byte update of the frame state
  always_comb begin
    byte_position_next    = pos + 3'd1;
    running_crc_next      = running_crc;
    first_word_next       = first_word;
    second_high_byte_next = second_high_byte;
    second_low_byte_next  = second_low_byte;
    crc_fail_seen_next    = crc_fail_seen;
    unique case (pos) inside
      swfc_pkg::POS_HI0: begin
        crc_fail_seen_next = 1'b0;
        running_crc_next   = swfc_pkg::crc8_update(swfc_pkg::CRC_INIT, b);
        first_word_next    = {b, 8'h00};
      end
      swfc_pkg::POS_LO0: begin
        running_crc_next = swfc_pkg::crc8_update(running_crc, b);
        first_word_next  = {first_word[15:8], b};
      end
      swfc_pkg::POS_CRC0, swfc_pkg::POS_CRC1: begin
        crc_fail_seen_next = crc_fail_seen || crc_bad;
        running_crc_next   = swfc_pkg::CRC_INIT;
      end
      swfc_pkg::POS_HI1: begin
        running_crc_next      = swfc_pkg::crc8_update(swfc_pkg::CRC_INIT, b);
        second_high_byte_next = b;
      end
      default: begin
        running_crc_next     = swfc_pkg::crc8_update(running_crc, b);
        second_low_byte_next = b;
      end
    endcase
    if (pos == swfc_pkg::POS_CRC1) begin
      byte_position_next = swfc_pkg::POS_HI0;
    end
  end

  // result on the last crc byte of the frame
  always_comb begin
    res.hit           = fire && (pos == swfc_pkg::POS_CRC1);
    res.data.co2_ppm  = first_word;
    res.data.voc_word = {second_high_byte, second_low_byte};
    res.data.status   = crc_fail_seen || crc_bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= swfc_pkg::POS_HI0;
      running_crc      <= swfc_pkg::CRC_INIT;
      first_word       <= '0;
      second_high_byte <= '0;
      second_low_byte  <= '0;
      crc_fail_seen    <= 1'b0;
    end else if (fire) begin
      byte_position    <= byte_position_next;
      running_crc      <= running_crc_next;
      first_word       <= first_word_next;
      second_high_byte <= second_high_byte_next;
      second_low_byte  <= second_low_byte_next;
      crc_fail_seen    <= crc_fail_seen_next;
    end
  end

endmodule

@@ rtl/swfc_out_stage.sv @@
module swfc_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  swfc_pkg::frame_res_t res,
  output logic                 load_ready,
  output logic                 result_valid,
  input  logic                 result_stall,
  output swfc_pkg::result_t    result
);

  // free, or being emptied this cycle
  assign load_ready = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_ready) begin
      result_valid <= res.hit;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (load_ready && res.hit) begin
      result <= res.data;
    end
  end

endmodule

@@ sim/tb_sensor_word_frame_crc_check.sv @@
`timescale 1ns / 100ps

module tb_sensor_word_frame_crc_check;

  localparam int RANDOM_ITEMS = 1650;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_ITEMS   = 200;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               rx_valid = 1'b0;
  logic               rx_stall;
  swfc_pkg::rx_item_t rx_item = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  swfc_pkg::result_t  result;

  sensor_word_frame_crc_check dut (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx_valid),
    .rx_stall     (rx_stall),
    .rx_item      (rx_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // tracks the reply frame as bytes are taken and holds the frames still owed
  class reply_frame_scoreboard;
    swfc_pkg::result_t pending_frames[$];
    int                mismatch_count;
    logic [2:0]        byte_pos;
    logic [7:0]        word_crc;
    logic [15:0]       co2_word;
    logic [7:0]        tvoc_hi;
    logic [7:0]        tvoc_lo;
    logic              crc_bad;

    function new();
      mismatch_count = 0;
      byte_pos = swfc_pkg::POS_HI0;
      word_crc = swfc_pkg::CRC_INIT;
      co2_word = '0;
      tvoc_hi  = '0;
      tvoc_lo  = '0;
      crc_bad  = 1'b0;
    endfunction

    // crc8 over one byte, feeding data bits msb first into the shift register
    static function logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
        fb = c[7] ^ b[i];
        c = {c[6:0], 1'b0};
        if (fb) c = c ^ swfc_pkg::CRC_POLY;
      end
      return c;
    endfunction

    function void note_request(swfc_pkg::rx_item_t it);
      logic [2:0]        p;
      swfc_pkg::result_t r;
      p = it.frame_start ? swfc_pkg::POS_HI0 : byte_pos;
      if (p > swfc_pkg::POS_CRC1) p = swfc_pkg::POS_HI0;
      case (p)
        swfc_pkg::POS_HI0: begin
          crc_bad  = 1'b0;
          word_crc = crc8_step(swfc_pkg::CRC_INIT, it.data_byte);
          co2_word = {it.data_byte, 8'h00};
        end
        swfc_pkg::POS_LO0: begin
          word_crc = crc8_step(word_crc, it.data_byte);
          co2_word = {co2_word[15:8], it.data_byte};
        end
        swfc_pkg::POS_CRC0, swfc_pkg::POS_CRC1: begin
          if (word_crc != it.data_byte) crc_bad = 1'b1;
          word_crc = swfc_pkg::CRC_INIT;
        end
        swfc_pkg::POS_HI1: begin
          word_crc = crc8_step(swfc_pkg::CRC_INIT, it.data_byte);
          tvoc_hi  = it.data_byte;
        end
        default: begin
          word_crc = crc8_step(word_crc, it.data_byte);
          tvoc_lo  = it.data_byte;
        end
      endcase
      if (p == swfc_pkg::POS_CRC1) begin
        r.co2_ppm  = co2_word;
        r.voc_word = {tvoc_hi, tvoc_lo};
        r.status   = crc_bad;
        pending_frames.push_back(r);
        byte_pos = swfc_pkg::POS_HI0;
      end else begin
        byte_pos = p + 3'd1;
      end
    endfunction

    function void check_result(swfc_pkg::result_t got);
      swfc_pkg::result_t want;
      if (pending_frames.size() == 0) begin
        $display("%0t: result with none expected, got co2 %h voc %h status %b",
                 $time, got.co2_ppm, got.voc_word, got.status);
        mismatch_count++;
        return;
      end
      want = pending_frames.pop_front();
      if (got.co2_ppm !== want.co2_ppm) begin
        $display("%0t: co2_ppm expected %h got %h", $time, want.co2_ppm, got.co2_ppm);
        mismatch_count++;
      end
      if (got.voc_word !== want.voc_word) begin
        $display("%0t: voc_word expected %h got %h", $time, want.voc_word, got.voc_word);
        mismatch_count++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %b got %b", $time, want.status, got.status);
        mismatch_count++;
      end
    endfunction
  endclass

  reply_frame_scoreboard sb = new();
  swfc_pkg::rx_item_t    byte_stream[$];
  bit                    hold_now = 1'b0;
  bit                    quiet = 1'b0;

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

  // watch both handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst && rx_valid && !rx_stall) sb.note_request(rx_item);
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  function automatic void add_byte(logic [7:0] b, logic fs);
    swfc_pkg::rx_item_t it;
    it.data_byte   = b;
    it.frame_start = fs;
    byte_stream.push_back(it);
  endfunction

  // one six-byte reply; a bad word gets its crc byte corrupted
  function automatic void add_frame(logic [15:0] w0, logic [15:0] w1, logic fs,
                                    bit bad0, bit bad1);
    logic [7:0] c0;
    logic [7:0] c1;
    c0 = reply_frame_scoreboard::crc8_step(
           reply_frame_scoreboard::crc8_step(swfc_pkg::CRC_INIT, w0[15:8]), w0[7:0]);
    c1 = reply_frame_scoreboard::crc8_step(
           reply_frame_scoreboard::crc8_step(swfc_pkg::CRC_INIT, w1[15:8]), w1[7:0]);
    if (bad0) c0 = c0 ^ 8'($urandom_range(1, 255));
    if (bad1) c1 = c1 ^ 8'($urandom_range(1, 255));
    add_byte(w0[15:8], fs);
    add_byte(w0[7:0], 1'b0);
    add_byte(c0, 1'b0);
    add_byte(w1[15:8], 1'b0);
    add_byte(w1[7:0], 1'b0);
    add_byte(c1, 1'b0);
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void build_stimulus();
    int  n;
    int  target;
    bit  force_start;
    // directed: good frame, wrap without frame start and a bad second word,
    // partial frame dropped by a frame start, then a bad first word
    add_frame(16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    add_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b1);
    add_byte(8'hA5, 1'b1);
    add_byte(8'h5A, 1'b0);
    add_frame(16'h8001, 16'h7FFE, 1'b1, 1'b1, 1'b0);
    // random: mostly well-formed replies, some broken frames and loose bytes
    target = byte_stream.size() + RANDOM_ITEMS;
    force_start = 1'b0;
    while (byte_stream.size() < target) begin
      n = $urandom_range(0, 99);
      if (n < 80) begin
        add_frame(pick_word(), pick_word(), force_start | 1'($urandom),
                  $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
        force_start = 1'b0;
      end else if (n < 92) begin
        n = $urandom_range(1, 5);
        add_byte(8'($urandom), force_start | 1'($urandom));
        for (int i = 1; i < n; i++) add_byte(8'($urandom), 1'b0);
        force_start = 1'b1;
      end else begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) add_byte(8'($urandom), 1'($urandom));
        force_start = 1'b1;
      end
    end
  endfunction

  task automatic send_request(swfc_pkg::rx_item_t it);
    @(negedge clk);
    rx_valid <= 1'b1;
    rx_item  <= it;
    do @(posedge clk); while (rx_stall);
  endtask

  task automatic sender_gap(int n);
    @(negedge clk);
    rx_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_now) begin
        hold_now = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 16);
        result_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // reset, then feed the byte stream
  initial begin
    int hold_at;
    int drain_at;
    build_stimulus();
    hold_at  = byte_stream.size() / 4;
    drain_at = byte_stream.size() / 2;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < byte_stream.size(); i++) begin
      if (i == byte_stream.size() - TAIL_ITEMS) quiet = 1'b1;
      if (i == hold_at) hold_now = 1'b1;
      // sender waits for every owed frame before going on
      if (i == drain_at) begin
        @(negedge clk);
        rx_valid <= 1'b0;
        while (sb.pending_frames.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        sender_gap($urandom_range(1, 16));
      end
      send_request(byte_stream[i]);
    end
    @(negedge clk);
    rx_valid <= 1'b0;
    while (sb.pending_frames.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending_frames.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
